@@ hdl/pcs_pkg.sv @@
`default_nettype none

package pcs_pkg;

	localparam int STACK_DEPTH   = 8;
	localparam int RECORD_BYTES  = 8;
	localparam int NUM_CLASSES   = 6;
	localparam int RATED_CLASSES = 5;

	localparam int WORD_W  = 64;
	localparam int LEN_W   = 4;
	localparam int CLASS_W = 3;
	localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W  = $clog2(NUM_CLASSES * STACK_DEPTH);
	localparam int SLOTS   = NUM_CLASSES * STACK_DEPTH;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_FETCH = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [LEN_W-1:0]   len_t;
	typedef logic [CLASS_W-1:0] class_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [ADDR_W-1:0]  addr_t;

	function automatic word_t byte_mask(input len_t len);
		word_t m;
		len_t  sat;
		m   = '0;
		sat = (len > LEN_W'(RECORD_BYTES)) ? LEN_W'(RECORD_BYTES) : len;
		for (int i = 0; i < WORD_W / 8; i++) begin
			if (LEN_W'(i) < sat) begin
				m[i*8 +: 8] = 8'hff;
			end
		end
		return m;
	endfunction

endpackage

`default_nettype wire

@@ hdl/pcs_ifs.sv @@
`default_nettype none

interface pcs_cmd_if
	import pcs_pkg::*;
();
	logic       valid;
	logic       ready;
	logic [1:0] op;
	class_t     class_index;
	word_t      record_word;
	len_t       record_len;

	modport source (output valid, output op, output class_index, output record_word,
		output record_len, input ready);
	modport sink (input valid, input op, input class_index, input record_word,
		input record_len, output ready);
endinterface

interface pcs_rsp_if
	import pcs_pkg::*;
();
	logic   valid;
	logic   ready;
	word_t  fetched_record;
	logic   fetch_found;
	class_t fetch_class;
	logic   push_accepted;
	logic   rated_pending;

	modport source (output valid, output fetched_record, output fetch_found,
		output fetch_class, output push_accepted, output rated_pending, input ready);
	modport sink (input valid, input fetched_record, input fetch_found,
		input fetch_class, input push_accepted, input rated_pending, output ready);
endinterface

`default_nettype wire

@@ hdl/priority_class_stack_set.sv @@
// Six LIFO stacks of 64-bit records, one per priority class (0 highest).
// cmd channel: one operation per transfer (push, fetch, clear, no-op).
// rsp channel: exactly one result transfer per command, in command order.
// Push, clear and no-op results are registered in the cycle after the command
// transfer; a fetch that finds data passes through ST_READ, as the record is
// read from the single synchronous record memory into rd_data_q first.
// Throughput: one command per cycle for push/clear/no-op while results are
// taken; a successful fetch holds off new commands during that memory read.
// The result sits in an output register; cmd.ready stays high while no fetch
// read is under way and that register is empty or being drained, so a new
// command overlaps the transfer of the previous result. When the receiver
// stalls, the held result keeps its value and cmd.ready drops until it is taken.
// Reset empties every stack at once through the per-class counters; the
// record memory needs no clearing, as only slots below a counter are read.
// A push keeps the low record_len bytes (saturated to the record size), a
// push to a full stack or to class 6 or 7 is dropped with push_accepted low.
`default_nettype none

module priority_class_stack_set
	import pcs_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	pcs_cmd_if.sink     cmd,
	pcs_rsp_if.source   rsp
);

	typedef enum logic {ST_IDLE, ST_READ} state_t;

	state_t state_q;
	cnt_t   cnt_q [NUM_CLASSES];
	word_t  mem [SLOTS];
	word_t  rd_data_q;

	logic   out_valid_q;
	word_t  rec_q;
	logic   found_q;
	class_t fcls_q;
	logic   acc_q;
	logic   rated_q;

	logic   accept;
	logic   push_ok;
	logic   any_ne;
	class_t push_cls, top_cls;
	cnt_t   push_cnt, top_cnt;
	cnt_t   cnt_d [NUM_CLASSES];
	logic   rated_d;
	addr_t  wr_addr, rd_addr;
	word_t  wr_data;
	logic   wr_en;

	assign cmd.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp.ready);
	assign accept    = cmd.valid && cmd.ready;
	assign push_cls  = cmd.class_index;

	always_comb begin
		push_cnt = '0;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			if (push_cls == CLASS_W'(c)) begin
				push_cnt = cnt_q[c];
			end
		end
	end

	always_comb begin
		any_ne  = 1'b0;
		top_cls = '0;
		top_cnt = '0;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (cnt_q[c] != '0) begin
				any_ne  = 1'b1;
				top_cls = CLASS_W'(c);
				top_cnt = cnt_q[c];
			end
		end
	end

	assign push_ok = (push_cls < CLASS_W'(NUM_CLASSES)) && (push_cnt < CNT_W'(STACK_DEPTH));

	always_comb begin
		for (int c = 0; c < NUM_CLASSES; c++) begin
			cnt_d[c] = cnt_q[c];
		end
		if (accept) begin
			unique case (cmd.op)
				OP_PUSH: begin
					for (int c = 0; c < NUM_CLASSES; c++) begin
						if (push_ok && push_cls == CLASS_W'(c)) begin
							cnt_d[c] = cnt_q[c] + CNT_W'(1);
						end
					end
				end
				OP_FETCH: begin
					for (int c = 0; c < NUM_CLASSES; c++) begin
						if (any_ne && top_cls == CLASS_W'(c)) begin
							cnt_d[c] = cnt_q[c] - CNT_W'(1);
						end
					end
				end
				OP_CLEAR: begin
					for (int c = 0; c < NUM_CLASSES; c++) begin
						cnt_d[c] = '0;
					end
				end
				default: begin
				end
			endcase
		end
		rated_d = 1'b0;
		for (int c = 0; c < RATED_CLASSES; c++) begin
			if (cnt_d[c] != '0) begin
				rated_d = 1'b1;
			end
		end
	end

	assign wr_en   = accept && (cmd.op == OP_PUSH) && push_ok;
	assign wr_addr = ADDR_W'(push_cls) * ADDR_W'(STACK_DEPTH) + ADDR_W'(push_cnt);
	assign wr_data = cmd.record_word & byte_mask(cmd.record_len);
	assign rd_addr = ADDR_W'(top_cls) * ADDR_W'(STACK_DEPTH) + ADDR_W'(top_cnt)
		- ADDR_W'(1);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				cnt_q[c] <= '0;
			end
		end else begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				cnt_q[c] <= cnt_d[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			rec_q       <= '0;
			found_q     <= 1'b0;
			fcls_q      <= '0;
			acc_q       <= 1'b0;
			rated_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rated_q <= rated_d;
						rec_q   <= '0;
						if (cmd.op == OP_FETCH && any_ne) begin
							found_q     <= 1'b1;
							fcls_q      <= top_cls;
							acc_q       <= 1'b0;
							out_valid_q <= 1'b0;
							state_q     <= ST_READ;
						end else begin
							found_q     <= 1'b0;
							fcls_q      <= '0;
							acc_q       <= (cmd.op == OP_PUSH) && push_ok;
							out_valid_q <= 1'b1;
						end
					end else if (out_valid_q && rsp.ready) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_READ: begin
					rec_q       <= rd_data_q;
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.fetched_record = rec_q;
	assign rsp.fetch_found    = found_q;
	assign rsp.fetch_class    = fcls_q;
	assign rsp.push_accepted  = acc_q;
	assign rsp.rated_pending  = rated_q;

`ifndef SYNTH
	a_read_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> !out_valid_q)
		else $error("fetch read with output register occupied");

	a_fetch_to_read: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.op == OP_FETCH && any_ne |=> state_q == ST_READ)
		else $error("successful fetch did not enter read state");

	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(found_q && acc_q))
		else $error("result reports both push and fetch");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.op == OP_PUSH && push_ok |=> push_cnt != '0 || push_cls != $past(push_cls))
		else $error("push did not raise stack count");
`endif

endmodule

`default_nettype wire
